/* design/mbrtu_pkg.sv */
// Shared constants, types and CRC helper for the Modbus RTU holding register slave.
package mbrtu_pkg;

    localparam int REG_COUNT   = 16;
    localparam int FRAME_MAX   = 256;
    localparam int STORE_DEPTH = 256;
    localparam int STORE_AW    = 8;
    localparam int CNT_W       = 9;
    localparam int REG_AW      = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int TXI_W       = $clog2(3 + 2 * REG_COUNT + 2);

    localparam logic [7:0] FC_READ      = 8'd3;
    localparam logic [7:0] FC_WRITE1    = 8'd6;
    localparam logic [7:0] FC_WRITEN    = 8'd16;
    localparam logic [7:0] EXC_FLAG     = 8'h80;
    localparam logic [7:0] EXC_ILL_FUNC = 8'h01;
    localparam logic [7:0] EXC_ILL_ADDR = 8'h02;
    localparam logic [7:0] EXC_DEV_FAIL = 8'h04;
    localparam logic [7:0] SA_RESET     = 8'd1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        RESP_EXC1,
        RESP_EXC2,
        RESP_EXC4,
        RESP_READ,
        RESP_ECHO
    } resp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR_RD,
        ST_HDR_CAP,
        ST_CHK,
        ST_CRC_RD,
        ST_CRC_CAP,
        ST_EXEC,
        ST_WR_RD,
        ST_WR_CAP,
        ST_TX
    } state_t;

    typedef struct packed {
        logic  byte_wr;
        logic  cnt_clr;
        logic  idx_clr;
        logic  rd_frame;
        logic  rd_fetch;
        logic  hdr_cap;
        logic  crc_init;
        logic  crc_cap;
        logic  reg_wr1;
        logic  fetch_cap;
        logic  tx_start;
        resp_t resp;
        logic  tx_load;
    } dp_cmd_t;

    typedef struct packed {
        logic short_frame;
        logic addr_ok;
        logic fc_ok;
        logic is_read;
        logic is_write1;
        logic start_ok;
        logic range_ok;
        logic crc_ok;
        logic qty_zero;
        logic hdr_done;
        logic crc_done;
        logic fetch_done;
        logic tx_ready;
        logic tx_final;
    } dp_sts_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* design/modbus_rtu_holding_register_slave.sv */
// Top level of the Modbus RTU holding register slave.
//
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   s_tdata = rx_byte, s_tuser = cmd
//  m_*       out        m_tvalid/m_tready   m_tdata = tx_byte, m_tlast = tx_last
//  cfg_*     in         cfg_wr_en           cfg_wr_data = slave_address
//
// A data byte is stored in the frame store. At end of frame the header is read, then
// the CRC is walked over the stored bytes, function 16 fetches its data, and the
// response is sent while m_tready allows. Input is refused from the end of a frame of
// four or more bytes until it is dropped or the last response beat is loaded.
// Reset clears the byte count and all holding registers; slave address returns to 1.
module modbus_rtu_holding_register_slave
    import mbrtu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       s_tuser,   // [0] cmd
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] tx_byte
    output logic       m_tlast,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    mbrtu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mbrtu_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx_byte     (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

/* design/mbrtu_ctrl.sv */
// Frame handling sequencer for the Modbus RTU holding register slave.
module mbrtu_ctrl
    import mbrtu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  logic    s_tuser,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.resp   = RESP_ECHO;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (!s_tuser)
                        cmd.byte_wr = 1'b1;
                    else if (sts.short_frame)
                        cmd.cnt_clr = 1'b1;
                    else
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_HDR_RD;
                    end
                end
            end
            ST_HDR_RD:
            begin
                cmd.rd_frame = 1'b1;
                state_next   = ST_HDR_CAP;
            end
            ST_HDR_CAP:
            begin
                cmd.hdr_cap = 1'b1;
                state_next  = sts.hdr_done ? ST_CHK : ST_HDR_RD;
            end
            ST_CHK:
            begin
                if (!sts.addr_ok)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (!sts.fc_ok)
                begin
                    cmd.tx_start = 1'b1;
                    cmd.resp     = RESP_EXC1;
                    state_next   = ST_TX;
                end
                else if (!sts.start_ok)
                begin
                    cmd.tx_start = 1'b1;
                    cmd.resp     = RESP_EXC2;
                    state_next   = ST_TX;
                end
                else
                begin
                    cmd.idx_clr  = 1'b1;
                    cmd.crc_init = 1'b1;
                    state_next   = ST_CRC_RD;
                end
            end
            ST_CRC_RD:
            begin
                cmd.rd_frame = 1'b1;
                state_next   = ST_CRC_CAP;
            end
            ST_CRC_CAP:
            begin
                cmd.crc_cap = 1'b1;
                state_next  = sts.crc_done ? ST_EXEC : ST_CRC_RD;
            end
            ST_EXEC:
            begin
                state_next   = ST_TX;
                cmd.tx_start = 1'b1;
                if (!sts.crc_ok)
                    cmd.resp = RESP_EXC4;
                else if (sts.is_read)
                    cmd.resp = sts.range_ok ? RESP_READ : RESP_EXC2;
                else if (sts.is_write1)
                begin
                    cmd.reg_wr1 = 1'b1;
                    cmd.resp    = RESP_ECHO;
                end
                else if (!sts.range_ok)
                    cmd.resp = RESP_EXC2;
                else if (sts.qty_zero)
                    cmd.resp = RESP_ECHO;
                else
                begin
                    cmd.tx_start = 1'b0;
                    cmd.idx_clr  = 1'b1;
                    state_next   = ST_WR_RD;
                end
            end
            ST_WR_RD:
            begin
                cmd.rd_fetch = 1'b1;
                state_next   = ST_WR_CAP;
            end
            ST_WR_CAP:
            begin
                cmd.fetch_cap = 1'b1;
                if (sts.fetch_done)
                begin
                    cmd.tx_start = 1'b1;
                    cmd.resp     = RESP_ECHO;
                    state_next   = ST_TX;
                end
                else
                    state_next = ST_WR_RD;
            end
            ST_TX:
            begin
                if (sts.tx_ready)
                begin
                    cmd.tx_load = 1'b1;
                    if (sts.tx_final)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/mbrtu_dp.sv */
// Frame store, holding registers, CRC and response datapath for the Modbus RTU slave.
module mbrtu_dp
    import mbrtu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic [7:0] rx_byte,
    input  dp_cmd_t    cmd,
    output dp_sts_t    sts,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic [7:0]       mem [STORE_DEPTH];
    logic [7:0]       rdata_reg;
    logic [STORE_AW-1:0] raddr;
    logic [STORE_AW-1:0] fetch_addr;

    logic [7:0]       sa_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [7:0]       hdr_reg [6];
    logic [15:0]      crc_reg;
    logic [15:0]      rcrc_reg;
    logic [7:0]       hi_reg;
    logic [15:0]      regs_reg [REG_COUNT];
    resp_t            resp_reg;
    logic [TXI_W-1:0] t_reg;
    logic [TXI_W-1:0] len_reg;
    logic             m_tvalid_reg;
    logic [7:0]       m_tdata_reg;
    logic             m_tlast_reg;

    logic [15:0]      start;
    logic [15:0]      qty;
    logic [16:0]      range_end;
    logic [CNT_W:0]   idx_p2;
    logic [REG_AW:0]  wr_sum;
    logic [REG_AW-1:0] wr_idx;
    logic [TXI_W-1:0] tj;
    logic [REG_AW:0]  rd_sum;
    logic [15:0]      rd_word;
    logic [7:0]       tx_data;
    logic [7:0]       exc_code;
    logic [TXI_W-1:0] len_new;

    assign start      = {hdr_reg[2], hdr_reg[3]};
    assign qty        = {hdr_reg[4], hdr_reg[5]};
    assign range_end  = {1'b0, start} + {1'b0, qty};
    assign idx_p2     = {1'b0, idx_reg} + (CNT_W+1)'(2);
    assign fetch_addr = idx_reg[STORE_AW-1:0] + STORE_AW'(7);
    assign raddr      = cmd.rd_fetch ? fetch_addr : idx_reg[STORE_AW-1:0];
    assign wr_sum     = {1'b0, start[REG_AW-1:0]} + {1'b0, idx_reg[REG_AW:1]};
    assign wr_idx     = wr_sum[REG_AW-1:0];
    assign tj         = t_reg - TXI_W'(3);
    assign rd_sum     = {1'b0, start[REG_AW-1:0]} + {1'b0, tj[REG_AW:1]};
    assign rd_word    = regs_reg[rd_sum[REG_AW-1:0]];

    always_comb
    begin
        sts.short_frame = cnt_reg < CNT_W'(4);
        sts.addr_ok     = hdr_reg[0] == sa_reg;
        sts.fc_ok       = (hdr_reg[1] == FC_READ) || (hdr_reg[1] == FC_WRITE1)
                          || (hdr_reg[1] == FC_WRITEN);
        sts.is_read     = hdr_reg[1] == FC_READ;
        sts.is_write1   = hdr_reg[1] == FC_WRITE1;
        sts.start_ok    = start < 16'(REG_COUNT);
        sts.range_ok    = range_end <= 17'(REG_COUNT);
        sts.crc_ok      = crc_reg == rcrc_reg;
        sts.qty_zero    = qty == 16'd0;
        sts.hdr_done    = idx_reg == CNT_W'(5);
        sts.crc_done    = ({1'b0, idx_reg} + (CNT_W+1)'(1)) == {1'b0, cnt_reg};
        sts.fetch_done  = ({8'd0, idx_reg} + 17'd1) == {qty, 1'b0};
        sts.tx_ready    = !m_tvalid_reg || m_tready;
        sts.tx_final    = t_reg == (len_reg + TXI_W'(1));
    end

    always_comb
    begin
        case (resp_reg)
            RESP_EXC1: exc_code = EXC_ILL_FUNC;
            RESP_EXC2: exc_code = EXC_ILL_ADDR;
            default:   exc_code = EXC_DEV_FAIL;
        endcase
    end

    always_comb
    begin
        case (cmd.resp)
            RESP_READ: len_new = TXI_W'(3) + TXI_W'({qty[TXI_W-2:0], 1'b0});
            RESP_ECHO: len_new = TXI_W'(6);
            default:   len_new = TXI_W'(3);
        endcase
    end

    always_comb
    begin
        tx_data = hdr_reg[0];
        if (t_reg == len_reg)
            tx_data = crc_reg[7:0];
        else if (t_reg == len_reg + TXI_W'(1))
            tx_data = crc_reg[15:8];
        else
        begin
            case (resp_reg)
                RESP_READ:
                begin
                    if (t_reg == TXI_W'(0))
                        tx_data = hdr_reg[0];
                    else if (t_reg == TXI_W'(1))
                        tx_data = hdr_reg[1];
                    else if (t_reg == TXI_W'(2))
                        tx_data = {qty[6:0], 1'b0};
                    else
                        tx_data = tj[0] ? rd_word[7:0] : rd_word[15:8];
                end
                RESP_ECHO:
                begin
                    tx_data = hdr_reg[t_reg[2:0]];
                end
                default:
                begin
                    if (t_reg == TXI_W'(0))
                        tx_data = hdr_reg[0];
                    else if (t_reg == TXI_W'(1))
                        tx_data = hdr_reg[1] | EXC_FLAG;
                    else
                        tx_data = exc_code;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.byte_wr && (cnt_reg < CNT_W'(FRAME_MAX)))
            mem[cnt_reg[STORE_AW-1:0]] <= rx_byte;
        if (cmd.rd_frame || cmd.rd_fetch)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hdr_cap)
            hdr_reg[idx_reg[2:0]] <= rdata_reg;
        if (cmd.crc_cap && (idx_p2 == {1'b0, cnt_reg}))
            rcrc_reg[7:0] <= rdata_reg;
        if (cmd.crc_cap && (idx_p2 > {1'b0, cnt_reg}))
            rcrc_reg[15:8] <= rdata_reg;
        if (cmd.fetch_cap && !idx_reg[0])
            hi_reg <= rdata_reg;
        if (cmd.tx_start)
        begin
            resp_reg <= cmd.resp;
            len_reg  <= len_new;
        end
        if (cmd.tx_load)
        begin
            m_tdata_reg <= tx_data;
            m_tlast_reg <= sts.tx_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_reg       <= SA_RESET;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            crc_reg      <= CRC_INIT;
            t_reg        <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++)
                regs_reg[i] <= 16'd0;
        end
        else
        begin
            if (cfg_wr_en)
                sa_reg <= cfg_wr_data;
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.byte_wr && (cnt_reg < CNT_W'(FRAME_MAX)))
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.hdr_cap || cmd.crc_cap || cmd.fetch_cap)
                idx_reg <= idx_reg + CNT_W'(1);
            if (cmd.crc_init || cmd.tx_start)
                crc_reg <= CRC_INIT;
            else if (cmd.crc_cap && (idx_p2 < {1'b0, cnt_reg}))
                crc_reg <= crc_byte(crc_reg, rdata_reg);
            else if (cmd.tx_load && (t_reg < len_reg))
                crc_reg <= crc_byte(crc_reg, tx_data);
            if (cmd.tx_start)
                t_reg <= '0;
            else if (cmd.tx_load)
                t_reg <= t_reg + TXI_W'(1);
            if (cmd.tx_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (cmd.reg_wr1)
                regs_reg[start[REG_AW-1:0]] <= qty;
            if (cmd.fetch_cap && idx_reg[0])
                regs_reg[wr_idx] <= {hi_reg, rdata_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* design/mbrtu_chk.sv */
// Port-level checker for the Modbus RTU holding register slave, with its bind.
module mbrtu_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("response beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("response beat changed while stalled");

    a_busy_tx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken in the middle of a response");

    a_byte_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> s_tready)
        else $error("data beat did not return to idle");

endmodule

bind modbus_rtu_holding_register_slave mbrtu_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
